// File: hdl/mcsr_pkg.sv
// ----------------------------------------------------------------------------
// mcsr_pkg
// Shared types and constants for the machine-mode CSR file: item layouts,
// operation codes, CSR addresses and status bit positions.
// ----------------------------------------------------------------------------
package mcsr_pkg;

    localparam int XLEN      = 64;
    localparam int ADDR_W    = 12;
    localparam int MODE_W    = 2;

    // operation codes carried in the mode field
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TRAP  = 2'd2;

    // CSR addresses
    localparam logic [ADDR_W-1:0] A_SATP     = 12'h180;
    localparam logic [ADDR_W-1:0] A_MSTATUS  = 12'h300;
    localparam logic [ADDR_W-1:0] A_MISA     = 12'h301;
    localparam logic [ADDR_W-1:0] A_MEDELEG  = 12'h302;
    localparam logic [ADDR_W-1:0] A_MIDELEG  = 12'h303;
    localparam logic [ADDR_W-1:0] A_MIE      = 12'h304;
    localparam logic [ADDR_W-1:0] A_MTVEC    = 12'h305;
    localparam logic [ADDR_W-1:0] A_MEPC     = 12'h341;
    localparam logic [ADDR_W-1:0] A_MCAUSE   = 12'h342;
    localparam logic [ADDR_W-1:0] A_PMPCFG0  = 12'h3A0;
    localparam logic [ADDR_W-1:0] A_PMPADDR0 = 12'h3B0;
    localparam logic [ADDR_W-1:0] A_MNSTATUS = 12'h744;
    localparam logic [ADDR_W-1:0] A_MHARTID  = 12'hF14;

    // mstatus bit positions
    localparam int BIT_MIE  = 3;
    localparam int BIT_MPIE = 7;

    // mtvec mode field
    localparam logic [XLEN-1:0] TVEC_MODE_MASK = 64'h3;

    // default masks for mstatus
    localparam logic [XLEN-1:0] DEF_STATUS_WRITE_MASK = 64'd6280;
    localparam logic [XLEN-1:0] DEF_STATUS_READ_MASK  = 64'd6280;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] csr_address;
        logic [XLEN-1:0]   write_value;
        logic [XLEN-1:0]   cause_value;
        logic [XLEN-1:0]   current_pc;
    } req_t;

    typedef struct packed {
        logic [XLEN-1:0] read_data;
        logic [XLEN-1:0] trap_vector;
        logic            illegal_access;
        logic            vector_mode_error;
    } rsp_t;

endpackage

// File: hdl/mcsr_if.sv
// ----------------------------------------------------------------------------
// mcsr_if
// Valid/ready stream interfaces for the CSR file request and response.
// ----------------------------------------------------------------------------
interface mcsr_req_if;
    import mcsr_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mcsr_rsp_if;
    import mcsr_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/machine_csr_file_with_trap_entry_top.sv
// ----------------------------------------------------------------------------
// machine_csr_file_with_trap_entry_top
// Machine-mode CSR file: CSR reads, masked/plain writes and trap entry.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per transfer: read, write or trap entry.
//   rsp returns exactly one result per request, in order.
//   An accepted request sits in the input register; its result is
//   computed from the CSR state there and lands in the output register
//   when the input register advances, where the CSR state is updated too.
//   Throughput is one request per cycle: the input register advances
//   whenever the output register is empty or being taken.
//   If rsp stalls, the output register holds its result and one more
//   request may wait in the input register; req.ready then drops.
//   Reset clears all CSRs and both valid flags; no request is lost or
//   replayed across a stall.
// ----------------------------------------------------------------------------
module machine_csr_file_with_trap_entry_top #(
    parameter logic [mcsr_pkg::XLEN-1:0] STATUS_WRITE_MASK = mcsr_pkg::DEF_STATUS_WRITE_MASK,
    parameter logic [mcsr_pkg::XLEN-1:0] STATUS_READ_MASK  = mcsr_pkg::DEF_STATUS_READ_MASK
) (
    input  logic       clk,
    input  logic       rst_n,
    mcsr_req_if.sink   req,
    mcsr_rsp_if.source rsp
);
    import mcsr_pkg::*;

    logic            s1_valid_reg;
    req_t            s1_item_reg;
    logic            out_valid_reg;
    rsp_t            out_item_reg;

    logic [XLEN-1:0] status_reg, status_next;
    logic [XLEN-1:0] tvec_reg, tvec_next;
    logic [XLEN-1:0] cause_reg, cause_next;
    logic [XLEN-1:0] epc_reg, epc_next;
    logic [XLEN-1:0] nmstatus_reg, nmstatus_next;

    logic            s1_advance;
    rsp_t            result;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready  = !s1_valid_reg || s1_advance;

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_item_reg;

    // result and next CSR state for the item in the input register
    always_comb
    begin
        status_next   = status_reg;
        tvec_next     = tvec_reg;
        cause_next    = cause_reg;
        epc_next      = epc_reg;
        nmstatus_next = nmstatus_reg;
        result        = '0;

        unique case (s1_item_reg.mode)
            MODE_READ:
            begin
                unique case (s1_item_reg.csr_address) inside
                    A_MSTATUS:                  result.read_data = status_reg & STATUS_READ_MASK;
                    A_MISA, A_MHARTID, A_SATP:  result.read_data = '0;
                    A_MTVEC:                    result.read_data = tvec_reg;
                    A_MCAUSE:                   result.read_data = cause_reg;
                    A_MEPC:                     result.read_data = epc_reg;
                    A_MNSTATUS:                 result.read_data = nmstatus_reg;
                    default:                    result.illegal_access = 1'b1;
                endcase
            end
            MODE_WRITE:
            begin
                unique case (s1_item_reg.csr_address) inside
                    A_SATP, A_PMPADDR0, A_PMPCFG0, A_MIE, A_MEDELEG, A_MIDELEG: ;
                    A_MSTATUS:
                        status_next = (status_reg & ~STATUS_WRITE_MASK)
                                    | (s1_item_reg.write_value & STATUS_WRITE_MASK);
                    A_MTVEC:    tvec_next     = s1_item_reg.write_value;
                    A_MCAUSE:   cause_next    = s1_item_reg.write_value;
                    A_MEPC:     epc_next      = s1_item_reg.write_value;
                    A_MNSTATUS: nmstatus_next = s1_item_reg.write_value;
                    default:    result.illegal_access = 1'b1;
                endcase
            end
            MODE_TRAP:
            begin
                status_next[BIT_MPIE]    = status_reg[BIT_MIE];
                status_next[BIT_MIE]     = 1'b0;
                cause_next               = s1_item_reg.cause_value;
                epc_next                 = s1_item_reg.current_pc;
                result.trap_vector       = tvec_reg & ~TVEC_MODE_MASK;
                result.vector_mode_error = |(tvec_reg & TVEC_MODE_MASK);
            end
            default: ;  // unused code: no effect, all-zero result
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            tvec_reg      <= '0;
            cause_reg     <= '0;
            epc_reg       <= '0;
            nmstatus_reg  <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
                status_reg    <= status_next;
                tvec_reg      <= tvec_next;
                cause_reg     <= cause_next;
                epc_reg       <= epc_next;
                nmstatus_reg  <= nmstatus_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            s1_item_reg <= req.payload;
        end
        if (s1_advance)
        begin
            out_item_reg <= result;
        end
    end

endmodule

// File: hdl/mcsr_checker.sv
// ----------------------------------------------------------------------------
// mcsr_checker
// Port-level checks on the CSR file response stream, bound to the top level.
// ----------------------------------------------------------------------------
module mcsr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [mcsr_pkg::XLEN-1:0]   rsp_read_data,
    input logic [mcsr_pkg::XLEN-1:0]   rsp_trap_vector,
    input logic                        rsp_illegal_access,
    input logic                        rsp_vector_mode_error
);
    import mcsr_pkg::*;

    // a stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp valid dropped while stalled");

    // handler address never carries mode bits
    a_vec_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_trap_vector & TVEC_MODE_MASK) == '0)
        else $error("trap vector has mode bits set");

    // an illegal access is a read or write only: no trap outputs, no data
    a_illegal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_illegal_access |->
            !rsp_vector_mode_error && rsp_trap_vector == '0 && rsp_read_data == '0)
        else $error("illegal access result carries data");

    // a trap result with mode bits set never carries read data
    a_trap_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_vector_mode_error |-> rsp_read_data == '0)
        else $error("trap result carries read data");

endmodule

bind machine_csr_file_with_trap_entry_top mcsr_checker u_mcsr_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .rsp_valid             (rsp.valid),
    .rsp_ready             (rsp.ready),
    .rsp_read_data         (rsp.payload.read_data),
    .rsp_trap_vector       (rsp.payload.trap_vector),
    .rsp_illegal_access    (rsp.payload.illegal_access),
    .rsp_vector_mode_error (rsp.payload.vector_mode_error)
);

// File: test/machine_csr_file_with_trap_entry_top_tb.sv
// ----------------------------------------------------------------------------
// machine_csr_file_with_trap_entry_top_tb
// Self-checking bench for the machine-mode CSR file. A directed sequence
// covers every CSR address, the ignored writes, the illegal addresses,
// the unused mode and traps with and without vector mode bits set. A long
// random sequence follows. A local copy of the CSR state predicts each
// response, and responses are compared in order, field by field.
// ----------------------------------------------------------------------------
module machine_csr_file_with_trap_entry_top_tb;
    import mcsr_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;   // unused code, no effect
    localparam int RANDOM_OPS = 2000;
    localparam int CALM_TAIL  = 200;   // last transfers run without idling
    localparam int LONG_HOLD  = 60;    // rsp back-pressure stretch, in cycles
    localparam int STALL_LIMIT = 1000; // cycles with no transfer at all

    typedef struct {
        req_t op;
        bit   drain;   // hold off until every response is back
    } queued_op_t;

    logic clk;
    logic rst_n;

    mcsr_req_if req_ch();
    mcsr_rsp_if rsp_ch();

    machine_csr_file_with_trap_entry_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // local CSR state
    logic [XLEN-1:0] m_status;
    logic [XLEN-1:0] m_tvec;
    logic [XLEN-1:0] m_cause;
    logic [XLEN-1:0] m_epc;
    logic [XLEN-1:0] m_nstatus;

    queued_op_t ops_queued[$];
    rsp_t       csr_results_due[$];

    int total_ops;
    int ops_accepted;
    int results_seen;
    int errors;
    int send_gap;
    int rsp_hold;
    int long_holds;
    int quiet_cycles;

    always #1 clk = ~clk;

    // Apply one operation to the local CSR state and return its response.
    function automatic rsp_t csr_apply(input req_t op);
        rsp_t r;
        logic mie_bit;
        r = '0;
        case (op.mode)
            MODE_READ:
            begin
                case (op.csr_address)
                    A_MSTATUS:                 r.read_data = m_status & DEF_STATUS_READ_MASK;
                    A_MISA, A_MHARTID, A_SATP: r.read_data = '0;
                    A_MTVEC:                   r.read_data = m_tvec;
                    A_MCAUSE:                  r.read_data = m_cause;
                    A_MEPC:                    r.read_data = m_epc;
                    A_MNSTATUS:                r.read_data = m_nstatus;
                    default:                   r.illegal_access = 1'b1;
                endcase
            end
            MODE_WRITE:
            begin
                case (op.csr_address)
                    A_SATP, A_PMPADDR0, A_PMPCFG0, A_MIE, A_MEDELEG, A_MIDELEG: ;
                    A_MSTATUS:  m_status = (m_status & ~DEF_STATUS_WRITE_MASK)
                                         | (op.write_value & DEF_STATUS_WRITE_MASK);
                    A_MTVEC:    m_tvec = op.write_value;
                    A_MCAUSE:   m_cause = op.write_value;
                    A_MEPC:     m_epc = op.write_value;
                    A_MNSTATUS: m_nstatus = op.write_value;
                    default:    r.illegal_access = 1'b1;
                endcase
            end
            MODE_TRAP:
            begin
                mie_bit = m_status[BIT_MIE];
                m_status[BIT_MPIE] = mie_bit;
                m_status[BIT_MIE] = 1'b0;
                m_cause = op.cause_value;
                m_epc = op.current_pc;
                r.vector_mode_error = |(m_tvec & TVEC_MODE_MASK);
                r.trap_vector = m_tvec & ~TVEC_MODE_MASK;
            end
            default: ;
        endcase
        return r;
    endfunction

    // 64-bit value, weighted toward the extremes
    function automatic logic [XLEN-1:0] any_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        else if (pick == 2)
            return XLEN'($urandom_range(0, 15));
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ADDR_W-1:0] any_address();
        if ($urandom_range(0, 99) < 12)
            return ADDR_W'($urandom);
        case ($urandom_range(0, 12))
            0:  return A_SATP;
            1:  return A_MSTATUS;
            2:  return A_MISA;
            3:  return A_MEDELEG;
            4:  return A_MIDELEG;
            5:  return A_MIE;
            6:  return A_MTVEC;
            7:  return A_MEPC;
            8:  return A_MCAUSE;
            9:  return A_PMPCFG0;
            10: return A_PMPADDR0;
            11: return A_MNSTATUS;
            default: return A_MHARTID;
        endcase
    endfunction

    task automatic queue_op(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr,
                            input logic [XLEN-1:0] wval, input logic [XLEN-1:0] cause,
                            input logic [XLEN-1:0] pc, input bit drain);
        queued_op_t q;
        q.op.mode = mode;
        q.op.csr_address = addr;
        q.op.write_value = wval;
        q.op.cause_value = cause;
        q.op.current_pc = pc;
        q.drain = drain;
        ops_queued.push_back(q);
    endtask

    task automatic check_field(input string name, input logic [XLEN-1:0] want,
                               input logic [XLEN-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // request driver
    always @(posedge clk)
    begin
        queued_op_t nxt;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                csr_results_due.push_back(csr_apply(req_ch.payload));
                ops_accepted++;
            end
            if (req_ch.valid && !req_ch.ready)
            begin
                // keep offering the same item
            end
            else if (send_gap > 0)
            begin
                req_ch.valid <= 1'b0;
                send_gap--;
            end
            else if (ops_queued.size() == 0)
            begin
                req_ch.valid <= 1'b0;
            end
            else if (ops_queued[0].drain && csr_results_due.size() != 0)
            begin
                req_ch.valid <= 1'b0;
            end
            else if (ops_queued.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
            begin
                req_ch.valid <= 1'b0;
                send_gap = $urandom_range(0, 2);
            end
            else
            begin
                nxt = ops_queued.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.payload <= nxt.op;
            end
        end
    end

    // response monitor and back-pressure
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (csr_results_due.size() == 0)
                begin
                    $display("%0t: response with none outstanding: actual %h", $time,
                             rsp_ch.payload);
                    errors++;
                end
                else
                begin
                    want = csr_results_due.pop_front();
                    check_field("read_data", want.read_data, rsp_ch.payload.read_data);
                    check_field("trap_vector", want.trap_vector, rsp_ch.payload.trap_vector);
                    check_field("illegal_access", XLEN'(want.illegal_access),
                                XLEN'(rsp_ch.payload.illegal_access));
                    check_field("vector_mode_error", XLEN'(want.vector_mode_error),
                                XLEN'(rsp_ch.payload.vector_mode_error));
                end
                results_seen++;
            end
            if (rsp_hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_hold--;
            end
            else if (long_holds < 2 && results_seen >= (long_holds + 1) * 500)
            begin
                // long stretch: the block fills and drops req ready
                rsp_ch.ready <= 1'b0;
                rsp_hold = LONG_HOLD - 1;
                long_holds++;
            end
            else if (results_seen < total_ops - CALM_TAIL && $urandom_range(0, 7) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_hold = $urandom_range(0, 2);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        int pick;
        logic [MODE_W-1:0] mode;
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready = 1'b0;
        m_status = '0;
        m_tvec = '0;
        m_cause = '0;
        m_epc = '0;
        m_nstatus = '0;
        ops_accepted = 0;
        results_seen = 0;
        errors = 0;
        send_gap = 0;
        rsp_hold = 0;
        long_holds = 0;
        quiet_cycles = 0;

        // directed: masked mstatus, trap with mode bits set, then aligned
        queue_op(MODE_WRITE, A_MSTATUS, '1, any_value(), any_value(), 1'b0);
        queue_op(MODE_READ, A_MSTATUS, any_value(), any_value(), any_value(), 1'b0);
        queue_op(MODE_WRITE, A_MTVEC, '1, any_value(), any_value(), 1'b0);
        queue_op(MODE_TRAP, A_MTVEC, any_value(), '1, '1, 1'b0);
        queue_op(MODE_READ, A_MCAUSE, any_value(), any_value(), any_value(), 1'b0);
        queue_op(MODE_READ, A_MEPC, any_value(), any_value(), any_value(), 1'b0);
        queue_op(MODE_READ, A_MSTATUS, any_value(), any_value(), any_value(), 1'b0);
        queue_op(MODE_WRITE, A_MTVEC, '0, any_value(), any_value(), 1'b0);
        queue_op(MODE_TRAP, A_MISA, any_value(), '0, '0, 1'b0);
        queue_op(MODE_READ, A_MTVEC, any_value(), any_value(), any_value(), 1'b0);
        queue_op(MODE_WRITE, A_MNSTATUS, '1, any_value(), any_value(), 1'b0);
        queue_op(MODE_READ, A_MNSTATUS, any_value(), any_value(), any_value(), 1'b0);
        // writes that are accepted and dropped
        queue_op(MODE_WRITE, A_SATP, '1, any_value(), any_value(), 1'b0);
        queue_op(MODE_WRITE, A_PMPCFG0, '1, any_value(), any_value(), 1'b0);
        queue_op(MODE_WRITE, A_PMPADDR0, '1, any_value(), any_value(), 1'b0);
        queue_op(MODE_WRITE, A_MIE, '1, any_value(), any_value(), 1'b0);
        queue_op(MODE_WRITE, A_MEDELEG, '1, any_value(), any_value(), 1'b0);
        queue_op(MODE_WRITE, A_MIDELEG, '1, any_value(), any_value(), 1'b0);
        queue_op(MODE_READ, A_SATP, any_value(), any_value(), any_value(), 1'b0);
        queue_op(MODE_READ, A_MISA, any_value(), any_value(), any_value(), 1'b0);
        queue_op(MODE_READ, A_MHARTID, any_value(), any_value(), any_value(), 1'b0);
        // unsupported addresses and the unused mode code
        queue_op(MODE_READ, '1, any_value(), any_value(), any_value(), 1'b0);
        queue_op(MODE_WRITE, '0, '1, any_value(), any_value(), 1'b0);
        queue_op(MODE_NONE, A_MTVEC, '1, '1, '1, 1'b0);
        queue_op(MODE_READ, A_MCAUSE, any_value(), any_value(), any_value(), 1'b0);

        for (i = 0; i < RANDOM_OPS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 38)
                mode = MODE_READ;
            else if (pick < 75)
                mode = MODE_WRITE;
            else if (pick < 95)
                mode = MODE_TRAP;
            else
                mode = MODE_NONE;
            queue_op(mode, any_address(), any_value(), any_value(), any_value(),
                     (i % 600) == 300);
        end
        total_ops = ops_queued.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (ops_accepted < total_ops || csr_results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (errors == 0 && csr_results_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: machine_csr_file_with_trap_entry_top.f
hdl/mcsr_pkg.sv
hdl/mcsr_if.sv
hdl/machine_csr_file_with_trap_entry_top.sv
hdl/mcsr_checker.sv
test/machine_csr_file_with_trap_entry_top_tb.sv
